// ===== sv/mrve_pkg.sv =====
package mrve_pkg;

	// Reset value of the unmapped chromosome code register.
	localparam logic [15:0] UNMAPPED_RESET = 16'hFFFF;

	// Default number of descriptors held between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Mate class codes, two bits each in the packed class byte.
	localparam logic [1:0] CLASS_SAME  = 2'd0;
	localparam logic [1:0] CLASS_CROSS = 2'd1;
	localparam logic [1:0] CLASS_NONE  = 2'd2;

	// Stream tags on the result bytes.
	localparam logic [1:0] STREAM_CLASS = 2'd0;
	localparam logic [1:0] STREAM_MATE  = 2'd1;
	localparam logic [1:0] STREAM_POS   = 2'd2;
	localparam logic [1:0] STREAM_LEN   = 2'd3;

	// One classified record, ready to be serialized by the back end.
	typedef struct packed {
		logic        err;
		logic        has_cls;
		logic [7:0]  cls_byte;
		logic        has_mate;
		logic [30:0] mate_val;
		logic [63:0] pos_zz;
		logic [31:0] len_zz;
	} desc_t;

	// Serializer phases.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_CLS,
		ST_MATE,
		ST_POS,
		ST_LEN
	} ser_state_t;

endpackage

// ===== sv/mate_record_varint_encoder.sv =====
// A record is written into the queue when taken, popped by the idle serializer, and its
// first result byte is then registered in the output register.
// Throughput: one result byte per cycle while out_ready allows; a record yields 1 to 21
// result bytes, sent one at a time by the single-byte output serializer. Records queue up ahead of it.
// Reset: arst_n clears the class packer, the queue and the serializer at once and
// sets the unmapped chromosome code to 65535.
module mate_record_varint_encoder import mrve_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] mate_ref_id,
	input  logic signed [63:0] mate_position,
	input  logic signed [31:0] template_length,
	input  logic [15:0]        own_ref_id,
	input  logic signed [63:0] own_position,
	input  logic               last_record,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         stream_id,
	output logic [7:0]         data_byte,
	output logic               last,
	output logic               error
);

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	desc_t q_wdata;
	desc_t q_rdata;

	// Front end: classification, class packing and field coding.
	mrve_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mate_ref_id     (mate_ref_id),
		.mate_position   (mate_position),
		.template_length (template_length),
		.own_ref_id      (own_ref_id),
		.own_position    (own_position),
		.last_record     (last_record),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_wdata         (q_wdata)
	);

	// Descriptor queue between the two halves.
	mrve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	// Back end: byte serializer.
	mrve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stream_id (stream_id),
		.data_byte (data_byte),
		.last      (last),
		.error     (error)
	);

endmodule

// ===== sv/mrve_front.sv =====
module mrve_front import mrve_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] mate_ref_id,
	input  logic signed [63:0] mate_position,
	input  logic signed [31:0] template_length,
	input  logic [15:0]        own_ref_id,
	input  logic signed [63:0] own_position,
	input  logic               last_record,
	input  logic               q_full,
	output logic               q_push,
	output desc_t              q_wdata
);

	logic [15:0] unmapped_q;
	logic [5:0]  pack_bits_q;
	logic [1:0]  pack_slot_q;

	logic        mate_none;
	logic        mate_err;
	logic        mate_same;
	logic [1:0]  cls;
	logic [7:0]  cls_byte;
	logic        flush;
	logic [63:0] pos_val;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Classify the mate against the own chromosome.
	always_comb begin
		mate_none = (mate_ref_id == 32'hFFFF_FFFF);
		mate_err  = mate_ref_id[31] && !mate_none;
		mate_same = (own_ref_id != unmapped_q)
			&& (mate_ref_id == {16'b0, own_ref_id});
		if (mate_none) begin
			cls = CLASS_NONE;
		end else if (mate_same) begin
			cls = CLASS_SAME;
		end else begin
			cls = CLASS_CROSS;
		end
		cls_byte = {2'b00, pack_bits_q} | ({6'b0, cls} << {pack_slot_q, 1'b0});
		flush    = (pack_slot_q == 2'd3) || last_record;
		pos_val  = (cls == CLASS_SAME) ? 64'(mate_position - own_position)
			: 64'(mate_position);
	end

	// Build the descriptor, with zigzag coding of the signed fields.
	always_comb begin
		q_wdata.err      = mate_err;
		q_wdata.has_cls  = flush;
		q_wdata.cls_byte = cls_byte;
		q_wdata.has_mate = (cls == CLASS_CROSS);
		q_wdata.mate_val = mate_ref_id[30:0];
		q_wdata.pos_zz   = {pos_val[62:0], 1'b0} ^ {64{pos_val[63]}};
		q_wdata.len_zz   = {template_length[30:0], 1'b0} ^ {32{template_length[31]}};
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unmapped_q <= UNMAPPED_RESET;
		end else if (cfg_wr_en) begin
			unmapped_q <= cfg_wr_data;
		end
	end

	// Class packer; an invalid record leaves it untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_bits_q <= '0;
			pack_slot_q <= '0;
		end else if (q_push && !mate_err) begin
			if (flush) begin
				pack_bits_q <= '0;
				pack_slot_q <= '0;
			end else begin
				pack_bits_q <= cls_byte[5:0];
				pack_slot_q <= pack_slot_q + 2'd1;
			end
		end
	end

endmodule

// ===== sv/mrve_queue.sv =====
module mrve_queue import mrve_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  rvalid,
	output desc_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	// Storage for queued descriptors.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/mrve_back.sv =====
module mrve_back import mrve_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  desc_t      q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] stream_id,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       error
);

	ser_state_t  state_q, state_n;
	desc_t       d_q;
	logic [63:0] val_q, val_n;
	logic        out_valid_q;
	logic [1:0]  stream_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        error_q;

	logic        emit;
	logic        vdone;
	logic        step_done;
	logic        item_done;
	logic        load;
	desc_t       src;
	logic [1:0]  stream_n;
	logic [7:0]  byte_n;
	logic        last_n;

	assign out_valid = out_valid_q;
	assign stream_id = stream_q;
	assign data_byte = byte_q;
	assign last      = last_q;
	assign error     = error_q;

	// Sequencer: one result byte per cycle whenever the output register frees up.
	always_comb begin
		emit      = (state_q != ST_IDLE) && (!out_valid_q || out_ready);
		vdone     = (val_q[63:7] == 57'd0);
		step_done = (state_q == ST_ERR) || (state_q == ST_CLS) || vdone;
		item_done = emit && step_done && ((state_q == ST_LEN) || (state_q == ST_ERR));
		q_pop     = q_valid && ((state_q == ST_IDLE) || item_done);
		src       = q_pop ? q_data : d_q;
		load      = q_pop || (emit && step_done);

		state_n = state_q;
		if (q_pop) begin
			if (src.err) begin
				state_n = ST_ERR;
			end else if (src.has_cls) begin
				state_n = ST_CLS;
			end else if (src.has_mate) begin
				state_n = ST_MATE;
			end else begin
				state_n = ST_POS;
			end
		end else if (emit && step_done) begin
			case (state_q)
				ST_CLS:  state_n = d_q.has_mate ? ST_MATE : ST_POS;
				ST_MATE: state_n = ST_POS;
				ST_POS:  state_n = ST_LEN;
				default: state_n = ST_IDLE;
			endcase
		end

		// Next varint value: a fresh field on a phase change, else shift out seven bits.
		val_n = val_q;
		if (load) begin
			case (state_n)
				ST_MATE: val_n = {33'b0, src.mate_val};
				ST_POS:  val_n = src.pos_zz;
				ST_LEN:  val_n = {32'b0, src.len_zz};
				default: val_n = '0;
			endcase
		end else if (emit) begin
			val_n = {7'b0, val_q[63:7]};
		end

		// Byte and tags of the result being produced.
		byte_n   = vdone ? val_q[7:0] : {1'b1, val_q[6:0]};
		stream_n = STREAM_CLASS;
		last_n   = 1'b0;
		case (state_q)
			ST_ERR: begin
				byte_n = 8'd0;
				last_n = 1'b1;
			end
			ST_CLS: begin
				byte_n = d_q.cls_byte;
			end
			ST_MATE: begin
				stream_n = STREAM_MATE;
			end
			ST_POS: begin
				stream_n = STREAM_POS;
			end
			ST_LEN: begin
				stream_n = STREAM_LEN;
				last_n   = vdone;
			end
			default: begin
				byte_n = 8'd0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working descriptor, varint shifter and output register.
	always_ff @(posedge clk) begin
		val_q <= val_n;
		if (q_pop) begin
			d_q <= q_data;
		end
		if (emit) begin
			stream_q <= stream_n;
			byte_q   <= byte_n;
			last_q   <= last_n;
			error_q  <= (state_q == ST_ERR);
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mrve_pkg::*;

	// Longest run of cycles with no transfer on either side before giving up.
	localparam int STALL_LIMIT = 3000;
	// Length of the long output hold-off that backs the encoder up.
	localparam int HOLD_CYCLES = 400;
	// Cycles allowed for a record in flight after the last expected byte.
	localparam int DRAIN_CYCLES = 4;

	// One read-pair record as it goes into the encoder.
	typedef struct {
		logic signed [31:0] mate_chrom;
		logic [63:0]        mate_loc;
		logic signed [31:0] tlen;
		logic [15:0]        own_chrom;
		logic [63:0]        own_pos;
		logic               last_rec;
	} record_t;

	// One tagged byte as it comes out of the encoder.
	typedef struct {
		logic [1:0] stream;
		logic [7:0] data;
		logic       last;
		logic       err;
	} result_t;

	// Keeps its own class packer and unmapped code, and the bytes still owed.
	class varint_scoreboard;
		logic [15:0] unmapped_code;
		logic [5:0]  pack_bits;
		logic [1:0]  pack_slot;
		result_t     owed_bytes[$];
		int          n_errors;
		int          rec_count;
		int          n_invalid;
		int          n_bytes;
		int          n_class_bytes;

		function new();
			unmapped_code = UNMAPPED_RESET;
			pack_bits = '0;
			pack_slot = '0;
		endfunction

		function int pending();
			return owed_bytes.size();
		endfunction

		function logic [63:0] zigzag(logic [63:0] v);
			return {v[62:0], 1'b0} ^ {64{v[63]}};
		endfunction

		// Splits a value into LEB128 bytes, low seven bits first.
		function void push_leb(logic [1:0] stream, logic [63:0] v);
			result_t res;
			logic [63:0] rest;
			rest = v;
			while (rest >= 64'h80) begin
				res = '{stream, {1'b1, rest[6:0]}, 1'b0, 1'b0};
				owed_bytes.push_back(res);
				rest = rest >> 7;
			end
			res = '{stream, rest[7:0], 1'b0, 1'b0};
			owed_bytes.push_back(res);
		endfunction

		// Works out every byte that an accepted record will produce.
		function void note_record(record_t r);
			result_t res;
			logic [1:0] cls;
			logic [7:0] cls_byte;
			logic [63:0] pos_val;
			logic [63:0] len_val;
			rec_count++;
			// A bad mate id yields one error byte and leaves the packer alone.
			if (r.mate_chrom < -32'sd1) begin
				res = '{STREAM_CLASS, 8'h00, 1'b1, 1'b1};
				owed_bytes.push_back(res);
				n_invalid++;
				return;
			end
			// An unmapped own read never matches a real mate chromosome.
			if (r.mate_chrom == -32'sd1)
				cls = CLASS_NONE;
			else if (r.own_chrom != unmapped_code && r.mate_chrom == {16'd0, r.own_chrom})
				cls = CLASS_SAME;
			else
				cls = CLASS_CROSS;
			// The class byte goes out when full or on the last record of a block.
			cls_byte = {2'b00, pack_bits} | ({6'd0, cls} << {pack_slot, 1'b0});
			if (pack_slot == 2'd3 || r.last_rec) begin
				res = '{STREAM_CLASS, cls_byte, 1'b0, 1'b0};
				owed_bytes.push_back(res);
				pack_bits = '0;
				pack_slot = '0;
			end else begin
				pack_bits = cls_byte[5:0];
				pack_slot = pack_slot + 2'd1;
			end
			if (cls == CLASS_CROSS)
				push_leb(STREAM_MATE, {32'd0, r.mate_chrom});
			// Same-chromosome positions are coded as a wrapping delta.
			pos_val = (cls == CLASS_SAME) ? r.mate_loc - r.own_pos : r.mate_loc;
			push_leb(STREAM_POS, zigzag(pos_val));
			len_val = {{32{r.tlen[31]}}, r.tlen};
			push_leb(STREAM_LEN, zigzag(len_val));
			owed_bytes[owed_bytes.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (got_v !== exp_v) begin
				$display("time %0t: %s mismatch, expected %0h, actual %0h",
					$time, name, exp_v, got_v);
				n_errors++;
			end
		endfunction

		// Matches one output transfer against the oldest owed byte.
		function void check_result(result_t got);
			result_t exp;
			n_bytes++;
			if (owed_bytes.size() == 0) begin
				$display("time %0t: unexpected output, stream %0h byte %0h last %0h error %0h",
					$time, got.stream, got.data, got.last, got.err);
				n_errors++;
				return;
			end
			exp = owed_bytes.pop_front();
			if (exp.stream == STREAM_CLASS && !exp.err)
				n_class_bytes++;
			compare_field("stream_id", {6'd0, exp.stream}, {6'd0, got.stream});
			compare_field("data_byte", exp.data, got.data);
			compare_field("last", {7'd0, exp.last}, {7'd0, got.last});
			compare_field("error", {7'd0, exp.err}, {7'd0, got.err});
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [15:0]        cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] mate_ref_id;
	logic signed [63:0] mate_position;
	logic signed [31:0] template_length;
	logic [15:0]        own_ref_id;
	logic signed [63:0] own_position;
	logic               last_record;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         stream_id;
	logic [7:0]         data_byte;
	logic               last;
	logic               error;

	varint_scoreboard sb = new();
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit rx_hold_req = 1'b0;
	bit rx_holding = 1'b0;
	int n_settings = 0;
	int idle_cycles = 0;

	mate_record_varint_encoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mate_ref_id    (mate_ref_id),
		.mate_position  (mate_position),
		.template_length(template_length),
		.own_ref_id     (own_ref_id),
		.own_position   (own_position),
		.last_record    (last_record),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.stream_id      (stream_id),
		.data_byte      (data_byte),
		.last           (last),
		.error          (error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Output side: ready in random bursts, plus one long hold-off on request.
	initial begin
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_holding = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Every output transfer is checked against the predicted bytes.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{stream_id, data_byte, last, error};
			sb.check_result(got);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("time %0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offers one record, with an optional random gap first, until it is taken.
	task automatic send_record(input record_t r);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mate_ref_id <= r.mate_chrom;
		mate_position <= r.mate_loc;
		template_length <= r.tlen;
		own_ref_id <= r.own_chrom;
		own_position <= r.own_pos;
		last_record <= r.last_rec;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_record(r);
	endtask

	task automatic send_fields(input logic signed [31:0] mate, input logic [63:0] mpos,
		input logic signed [31:0] tl, input logic [15:0] own, input logic [63:0] opos,
		input logic lr);
		record_t r;
		r = '{mate, mpos, tl, own, opos, lr};
		send_record(r);
	endtask

	// Values spread over every LEB128 length, both signs.
	function automatic logic [63:0] rand_span64();
		logic [63:0] v;
		v = {$urandom, $urandom} >> $urandom_range(0, 63);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Mostly well-formed records, biased toward chromosome matches and the unmapped code.
	function automatic record_t random_record(logic [15:0] code);
		record_t r;
		int pick;
		pick = $urandom_range(0, 3);
		case (pick)
			0: r.own_chrom = code;
			1: r.own_chrom = 16'($urandom);
			2: r.own_chrom = 16'($urandom_range(0, 8));
			default: r.own_chrom = code + 16'd1;
		endcase
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			r.mate_chrom = $urandom_range(0, 1) ? -32'sd2 : ($urandom | 32'h8000_0000);
			if (r.mate_chrom == -32'sd1)
				r.mate_chrom = -32'sd2;
		end else if (pick <= 2) begin
			r.mate_chrom = -32'sd1;
		end else if (pick <= 5) begin
			r.mate_chrom = {16'd0, r.own_chrom};
		end else if (pick <= 8) begin
			r.mate_chrom = $urandom_range(0, 1) ? ($urandom & 32'h7FFF_FFFF)
				: $urandom_range(0, 300);
		end else begin
			r.own_chrom = code;
			r.mate_chrom = $urandom_range(0, 65535);
		end
		r.mate_loc = rand_span64();
		r.own_pos = $urandom_range(0, 1) ? r.mate_loc - {32'd0, $urandom_range(0, 2000)}
			: rand_span64();
		r.tlen = $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 1))
			r.tlen = -r.tlen;
		r.last_rec = ($urandom_range(0, 5) == 0);
		return r;
	endfunction

	task automatic run_random(input int count);
		repeat (count)
			send_record(random_record(sb.unmapped_code));
	endtask

	// Waits until the encoder has delivered everything it owes.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_code(input logic [15:0] code);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.unmapped_code = code;
		n_settings++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		mate_ref_id = '0;
		mate_position = '0;
		template_length = '0;
		own_ref_id = '0;
		own_position = '0;
		last_record = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records under the reset unmapped code.
		n_settings = 1;
		send_fields(-32'sd1, 64'd0, 32'sd0, 16'd0, 64'd0, 1'b0);
		send_fields(32'sd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 16'd0,
			64'h8000_0000_0000_0000, 1'b0);
		send_fields(32'h7FFF_FFFF, 64'h8000_0000_0000_0000, 32'h8000_0000, 16'd1,
			64'd5, 1'b0);
		// Fourth class fills the byte; the own read is unmapped so this is cross.
		send_fields(32'sd5, '1, -32'sd1, 16'hFFFF, 64'd0, 1'b0);
		// Bad mate ids, one marked last, must not flush anything.
		send_fields(-32'sd2, '1, 32'sd7, 16'd3, '1, 1'b1);
		send_fields(32'h8000_0000, 64'd1, 32'sd1, 16'hFFFF, 64'd1, 1'b0);
		// Unmapped read with no mate, flushed alone.
		send_fields(-32'sd1, 64'h7FFF_FFFF_FFFF_FFFF, 32'sd1, 16'hFFFF, 64'd0, 1'b1);
		send_fields(32'sd3, 64'd100, 32'sd63, 16'd3, 64'd200, 1'b0);
		send_fields(32'sd4, 64'd63, 32'sd64, 16'd3, 64'd0, 1'b1);
		send_fields(32'sd65535, 64'd64, -32'sd64, 16'hFFFF, 64'd0, 1'b0);
		send_fields(32'sd127, 64'd128, -32'sd65, 16'd10, 64'd0, 1'b0);
		send_fields(32'sd128, -64'sd1, 32'sd8192, 16'd10, 64'd0, 1'b0);
		send_fields(-32'sd1, 64'd0, 32'h4000_0000, 16'd7, 64'd0, 1'b1);
		send_fields(32'sd0, 64'd0, 32'sd0, 16'd0, 64'd0, 1'b1);
		send_fields(32'sd1, 64'd9, 32'sd2, 16'd1, 64'd9, 1'b0);
		send_fields(-32'sd100, 64'd0, 32'sd0, 16'd1, 64'd0, 1'b0);
		send_fields(-32'sd1, 64'h8000_0000_0000_0000, -32'sd2, 16'hFFFE, 64'd0, 1'b1);
		drain();

		// Code zero, starting with the output held off while records pile up.
		write_code(16'd0);
		rx_hold_req = 1'b1;
		wait (rx_holding);
		tx_idle_on = 1'b0;
		run_random(12);
		tx_idle_on = 1'b1;
		run_random(22);
		drain();

		write_code(16'hFFFF);
		run_random(34);
		drain();

		write_code(16'($urandom));
		run_random(34);
		drain();

		// Closing stretch at full rate on both sides.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_code(16'd3);
		run_random(30);
		drain();

		$display("Run covered %0d records (%0d with a bad mate id) over %0d unmapped codes,",
			sb.rec_count, sb.n_invalid, n_settings);
		$display("checking %0d output transfers, %0d of them packed class bytes.",
			sb.n_bytes, sb.n_class_bytes);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mrve_pkg.sv
sv/mrve_front.sv
sv/mrve_queue.sv
sv/mrve_back.sv
sv/mate_record_varint_encoder.sv
tb/testbench.sv
